[rtl/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg
// shared widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package fdd_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 24;
    localparam int Q_W       = 48;
    localparam int DIV_NUM_W = 59;
    localparam int DIV_DEN_W = 33;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd1;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd16;
    localparam logic [CFG_W-1:0] WIN_RESET = 7'd3;

    typedef enum logic [1:0] {
        OP_SLOPE,
        OP_S1,
        OP_CURV,
        OP_WIN
    } t_op;

    typedef enum logic [2:0] {
        RD_B,
        RD_A,
        RD_OLD,
        RD_WA,
        RD_WB
    } t_rd;

    typedef struct packed {
        logic accept;
        logic rd_capt;
        t_rd  rd_sel;
        logic div_start;
        logic store;
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic run;
        logic div_done;
    } t_sts;

endpackage

[rtl/fdd_ram.sv]
// ----------------------------------------------------------------------------
// fdd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fdd_div.sv]
// ----------------------------------------------------------------------------
// fdd_div
// radix-2 restoring divider, magnitude in, magnitude and sign out
// ----------------------------------------------------------------------------
module fdd_div import fdd_pkg::*; #(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_neg,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);

    localparam int CNW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNW-1:0]   r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic             r_neg;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_rem   = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= w_rem[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_neg  = r_neg;

endmodule

[rtl/fdd_datapath.sv]
// ----------------------------------------------------------------------------
// fdd_datapath
// config registers, sample window store, operand selection and result regs
// ----------------------------------------------------------------------------
module fdd_datapath import fdd_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [TIME_W-1:0]       i_sample_time,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic signed [VAL_W-1:0] o_oldest_value,
    output logic signed [Q_W-1:0]   o_slope,
    output logic signed [Q_W-1:0]   o_curvature,
    output logic signed [Q_W-1:0]   o_window_slope,
    output logic                    o_saturated
);

    localparam int SW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam int KW = ((HW > CFG_W) ? HW : CFG_W) + 1;
    localparam int EW = TIME_W + VAL_W;
    localparam int SHW = Q_W + 18;
    localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);
    localparam logic [DIV_NUM_W-1:0] MAG_MAX = DIV_NUM_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [DIV_NUM_W-1:0] MAG_MIN = DIV_NUM_W'(48'h8000_0000_0000);

    typedef enum logic [1:0] {
        WIN_NONE,
        WIN_ONE,
        WIN_MID
    } t_win;

    logic [CFG_W-1:0] r_cap;
    logic [CFG_W-1:0] r_win;
    logic [SW-1:0]    r_newest;
    logic [HW-1:0]    r_held;

    logic [TIME_W-1:0]       r_tin, r_tb, r_ta, r_twa, r_twb;
    logic signed [VAL_W-1:0] r_vin, r_vb, r_va, r_vwa, r_vwb, r_old;
    logic signed [Q_W-1:0]   r_slope, r_s1, r_curv, r_wslope;
    logic                    r_sat;

    logic signed [VAL_W-1:0] r_o_old;
    logic signed [Q_W-1:0]   r_o_slope, r_o_curv, r_o_wslope;
    logic                    r_o_sat;

    // window bookkeeping
    logic [KW-1:0] w_cap_eff, w_held_inc, w_win_k, w_held_k, w_m, w_bwa;
    logic [HW-1:0] n_held;
    logic [SW-1:0] n_newest;
    t_win          w_mode;
    logic [HW-1:0] w_back;
    logic [SW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    // operands
    logic [TIME_W-1:0]    w_dt_b, w_dt_a, w_dt_w;
    logic signed [Q_W:0]  w_diff;
    logic [Q_W:0]         w_mag;
    logic [SHW-1:0]       w_sh;
    logic [DIV_DEN_W-1:0] w_den;
    logic                 w_run;
    logic                 w_ge2, w_ge3;

    // divider
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quo;
    logic                 w_quo_neg;
    logic signed [Q_W-1:0] w_res;
    logic                 w_clip;

    function automatic logic [SW-1:0] f_slot(input logic [SW-1:0] newest,
                                             input logic [HW-1:0] back);
        logic [HW:0] sum;
        begin
            sum = (HW+1)'(newest) + (HW+1)'(CAPACITY) - (HW+1)'(back);
            if (sum >= (HW+1)'(CAPACITY)) begin
                sum = sum - (HW+1)'(CAPACITY);
            end
            return sum[SW-1:0];
        end
    endfunction

    always_comb begin
        w_cap_eff = KW'(r_cap);
        if (w_cap_eff == '0) begin
            w_cap_eff = KW'(1);
        end else if (w_cap_eff > CAP_K) begin
            w_cap_eff = CAP_K;
        end
        w_held_inc = KW'(r_held) + KW'(1);
        n_held     = (w_held_inc > w_cap_eff) ? r_held : w_held_inc[HW-1:0];
        if (r_held == '0) begin
            n_newest = r_newest;
        end else if (r_newest == SW'(CAPACITY - 1)) begin
            n_newest = '0;
        end else begin
            n_newest = r_newest + SW'(1);
        end
    end

    // window span after the push
    always_comb begin
        w_win_k  = KW'(r_win);
        w_held_k = KW'(r_held);
        w_m      = (w_held_k < w_win_k) ? w_held_k : w_win_k;
        w_bwa    = w_m - (w_m >> 1);
        if (w_win_k < KW'(2) || w_m < KW'(2)) begin
            w_mode = WIN_NONE;
        end else if (w_m == KW'(2)) begin
            w_mode = WIN_ONE;
        end else begin
            w_mode = WIN_MID;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_B:    w_back = HW'(1);
            RD_A:    w_back = HW'(2);
            RD_OLD:  w_back = r_held - HW'(1);
            RD_WA:   w_back = w_bwa[HW-1:0];
            RD_WB:   w_back = w_bwa[HW-1:0] - HW'(2);
            default: w_back = '0;
        endcase
        w_raddr = f_slot(r_newest, w_back);
    end

    fdd_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (n_newest),
        .i_wdata ({i_sample_time, i_sample_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_win    <= WIN_RESET;
            r_newest <= '0;
            r_held   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CAPACITY: r_cap <= i_cfg_data;
                    REG_WINDOW:   r_win <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_cmd.accept) begin
                r_newest <= n_newest;
                r_held   <= n_held;
            end
        end
    end

    // operand select for the shared divider
    always_comb begin
        w_dt_b = r_tin - r_tb;
        w_dt_a = r_tb - r_ta;
        w_dt_w = r_twb - r_twa;
        w_ge2  = (r_held >= HW'(2));
        w_ge3  = (r_held >= HW'(3));
        unique case (i_cmd.op)
            OP_SLOPE: begin
                w_diff = (Q_W+1)'(r_vin) - (Q_W+1)'(r_vb);
                w_den  = DIV_DEN_W'(w_dt_b);
                w_run  = w_ge2 && (w_dt_b != '0);
            end
            OP_S1: begin
                w_diff = (Q_W+1)'(r_vb) - (Q_W+1)'(r_va);
                w_den  = DIV_DEN_W'(w_dt_a);
                w_run  = w_ge3 && (w_dt_a != '0) && (w_dt_b != '0);
            end
            OP_CURV: begin
                w_diff = (Q_W+1)'(r_slope) - (Q_W+1)'(r_s1);
                w_den  = DIV_DEN_W'(w_dt_a) + DIV_DEN_W'(w_dt_b);
                w_run  = w_ge3 && (w_dt_a != '0) && (w_dt_b != '0);
            end
            default: begin
                w_diff = (Q_W+1)'(r_vwb) - (Q_W+1)'(r_vwa);
                w_den  = DIV_DEN_W'(w_dt_w);
                w_run  = (w_mode == WIN_MID) && (w_dt_w != '0);
            end
        endcase
        w_mag = w_diff[Q_W] ? (Q_W+1)'(-w_diff) : (Q_W+1)'(w_diff);
        w_sh  = (i_cmd.op == OP_CURV) ? {w_mag, 17'b0} : {1'b0, w_mag, 16'b0};
    end

    fdd_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_neg   (w_diff[Q_W]),
        .i_num   (w_sh[DIV_NUM_W-1:0]),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_neg   (w_quo_neg)
    );

    // clip the quotient to the signed q32.16 range; with no division, a two-point window takes the slope, else zero
    always_comb begin
        w_clip = 1'b0;
        if (w_run) begin
            if (!w_quo_neg) begin
                if (w_quo > MAG_MAX) begin
                    w_res  = 48'sh7FFF_FFFF_FFFF;
                    w_clip = 1'b1;
                end else begin
                    w_res = w_quo[Q_W-1:0];
                end
            end else begin
                if (w_quo > MAG_MIN) begin
                    w_res  = 48'sh8000_0000_0000;
                    w_clip = 1'b1;
                end else begin
                    w_res = -w_quo[Q_W-1:0];
                end
            end
        end else if (i_cmd.op == OP_WIN && w_mode == WIN_ONE) begin
            w_res = r_slope;
        end else begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tin <= i_sample_time;
            r_vin <= i_sample_value;
            r_sat <= 1'b0;
        end
        if (i_cmd.rd_capt) begin
            unique case (i_cmd.rd_sel)
                RD_B: begin
                    r_tb <= w_rdata[EW-1:VAL_W];
                    r_vb <= w_rdata[VAL_W-1:0];
                end
                RD_A: begin
                    r_ta <= w_rdata[EW-1:VAL_W];
                    r_va <= w_rdata[VAL_W-1:0];
                end
                RD_OLD: r_old <= w_rdata[VAL_W-1:0];
                RD_WA: begin
                    r_twa <= w_rdata[EW-1:VAL_W];
                    r_vwa <= w_rdata[VAL_W-1:0];
                end
                RD_WB: begin
                    r_twb <= w_rdata[EW-1:VAL_W];
                    r_vwb <= w_rdata[VAL_W-1:0];
                end
                default: ;
            endcase
        end
        if (i_cmd.store) begin
            unique case (i_cmd.op)
                OP_SLOPE: r_slope  <= w_res;
                OP_S1:    r_s1     <= w_res;
                OP_CURV:  r_curv   <= w_res;
                OP_WIN:   r_wslope <= w_res;
            endcase
            if (w_clip) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_o_old    <= r_old;
            r_o_slope  <= r_slope;
            r_o_curv   <= r_curv;
            r_o_wslope <= r_wslope;
            r_o_sat    <= r_sat;
        end
    end

    assign o_sts.run      = w_run;
    assign o_sts.div_done = w_div_done;

    assign o_oldest_value = r_o_old;
    assign o_slope        = r_o_slope;
    assign o_curvature    = r_o_curv;
    assign o_window_slope = r_o_wslope;
    assign o_saturated    = r_o_sat;

endmodule

[rtl/fdd_ctrl.sv]
// ----------------------------------------------------------------------------
// fdd_ctrl
// sequencer: push, five store reads, up to four divisions, result handoff
// ----------------------------------------------------------------------------
module fdd_ctrl import fdd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LATCH,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_rd    r_rd;
    t_op    r_op;
    logic   r_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd           = '0;
        w_cmd.rd_sel    = r_rd;
        w_cmd.op        = r_op;
        w_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        w_cmd.rd_capt   = (r_state == S_LATCH);
        w_cmd.div_start = (r_state == S_DSTART) && i_sts.run;
        w_cmd.store     = ((r_state == S_DSTART) && !i_sts.run) ||
                          ((r_state == S_DWAIT) && i_sts.div_done);
        w_cmd.load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd        <= RD_B;
            r_op        <= OP_SLOPE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_cmd.accept) begin
                        r_rd    <= RD_B;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_LATCH;
                S_LATCH: begin
                    unique case (r_rd)
                        RD_B:    r_rd <= RD_A;
                        RD_A:    r_rd <= RD_OLD;
                        RD_OLD:  r_rd <= RD_WA;
                        RD_WA:   r_rd <= RD_WB;
                        default: r_rd <= RD_B;
                    endcase
                    if (r_rd == RD_WB) begin
                        r_op    <= OP_SLOPE;
                        r_state <= S_DSTART;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_DSTART, S_DWAIT: begin
                    if (w_cmd.div_start) begin
                        r_state <= S_DWAIT;
                    end else if (w_cmd.store) begin
                        unique case (r_op)
                            OP_SLOPE: r_op <= OP_S1;
                            OP_S1:    r_op <= OP_CURV;
                            OP_CURV:  r_op <= OP_WIN;
                            OP_WIN:   r_op <= OP_SLOPE;
                        endcase
                        r_state <= (r_op == OP_WIN) ? S_DONE : S_DSTART;
                    end
                end
                S_DONE: begin
                    if (w_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

[rtl/finite_difference_derivative.sv]
// ----------------------------------------------------------------------------
// finite_difference_derivative
// sliding window of timestamped samples with first, second and windowed
// difference estimates in signed q32.16
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  --------------------------------
//  sample    in         i_in_valid / o_in_stall   i_sample_time, i_sample_value
//  result    out        o_out_valid / i_out_stall oldest, slope, curvature,
//                                                 window slope, saturated
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one sample transaction reads the store, then runs each division it needs
//  (up to four) on the 59-step radix-2 divider shared by all four quotients
//  the window store is written on acceptance and then read one entry at a time
//  through its single registered read port, each via a read and a latch state
//  reset (synchronous, active low) clears the control state and restores
//  the config defaults; unwritten store entries never feed a result
//  a result waits in the output register while the next sample is taken;
//  a stall holds only the final handoff
//
module finite_difference_derivative import fdd_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // sample transactions
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [TIME_W-1:0]       i_sample_time,
    input  logic signed [VAL_W-1:0] i_sample_value,
    // result transactions
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_oldest_value,
    output logic signed [Q_W-1:0]   o_slope,
    output logic signed [Q_W-1:0]   o_curvature,
    output logic signed [Q_W-1:0]   o_window_slope,
    output logic                    o_saturated,
    // config writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    fdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // window store, divider and result registers
    fdd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_oldest_value (o_oldest_value),
        .o_slope        (o_slope),
        .o_curvature    (o_curvature),
        .o_window_slope (o_window_slope),
        .o_saturated    (o_saturated)
    );

`ifndef SYNTHESIS
    // a taken sample blocks the next one while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sample accepted while previous one in progress");

    // only the curvature can leave the q32.16 range
    a_sat_on_curv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_curvature == 48'sh7FFF_FFFF_FFFF || o_curvature == 48'sh8000_0000_0000))
        else $error("saturation flagged without a clipped curvature");

    // a divider start never lands while the divider reports completion
    a_no_start_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_sts.div_done)
        else $error("divider restarted while finishing");
`endif

endmodule

[tb/sv/fdd_checker.sv]
// ----------------------------------------------------------------------------
// fdd_checker
// watches the sample, result and config channels, predicts each result from
// its own copy of the window and compares field by field
// ----------------------------------------------------------------------------
module fdd_checker import fdd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [TIME_W-1:0]       i_sample_time,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [VAL_W-1:0] i_oldest_value,
    input  logic signed [Q_W-1:0]   i_slope,
    input  logic signed [Q_W-1:0]   i_curvature,
    input  logic signed [Q_W-1:0]   i_window_slope,
    input  logic                    i_saturated,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;

    typedef struct {
        logic signed [VAL_W-1:0] oldest;
        logic signed [Q_W-1:0]   slope;
        logic signed [Q_W-1:0]   curv;
        logic signed [Q_W-1:0]   wslope;
        logic                    sat;
    } t_deriv;

    logic [TIME_W-1:0] win_time [CAPACITY_DEF];
    longint            win_val  [CAPACITY_DEF];
    int                head_slot;
    int                fill;
    logic [CFG_W-1:0]  cap_reg;
    logic [CFG_W-1:0]  pts_reg;
    logic              clipped;
    t_deriv            deriv_q [$];

    assign o_pending = deriv_q.size();

    // position 0 is the oldest held point
    function automatic int slot_of(int pos);
        int back;
        back = fill - 1 - pos;
        return (head_slot + CAPACITY_DEF - (back % CAPACITY_DEF)) % CAPACITY_DEF;
    endfunction

    function automatic longint div_tz(longint num, longint den);
        return num / den;   // signed division truncates toward zero
    endfunction

    function automatic longint diff_quot(int pa, int pb);
        logic [TIME_W-1:0] dt;
        dt = win_time[slot_of(pb)] - win_time[slot_of(pa)];
        if (dt == 0) return 0;
        return div_tz((win_val[slot_of(pb)] - win_val[slot_of(pa)]) * 65536,
                      longint'({32'd0, dt}));
    endfunction

    function automatic longint clip_q(longint x);
        if (x > Q_MAX) begin
            clipped = 1'b1;
            return Q_MAX;
        end
        if (x < Q_MIN) begin
            clipped = 1'b1;
            return Q_MIN;
        end
        return x;
    endfunction

    task automatic push_and_predict(input logic [TIME_W-1:0] t,
                                    input logic signed [VAL_W-1:0] v);
        int                eff_cap;
        int                m;
        int                mid;
        logic [TIME_W-1:0] dt1, dt2;
        longint            s1, s2, sl, cv, ws;
        t_deriv            d;
        eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > CAPACITY_DEF) ? CAPACITY_DEF : cap_reg);
        if (fill != 0) head_slot = (head_slot + 1) % CAPACITY_DEF;
        win_time[head_slot] = t;
        win_val[head_slot]  = longint'(v);
        fill++;
        if (fill > eff_cap) fill--;
        clipped = 1'b0;
        sl = 0;
        cv = 0;
        ws = 0;
        if (fill >= 2) sl = clip_q(diff_quot(fill - 2, fill - 1));
        if (fill >= 3) begin
            dt1 = win_time[slot_of(fill - 2)] - win_time[slot_of(fill - 3)];
            dt2 = win_time[slot_of(fill - 1)] - win_time[slot_of(fill - 2)];
            if (dt1 != 0 && dt2 != 0) begin
                s1 = diff_quot(fill - 3, fill - 2);
                s2 = diff_quot(fill - 2, fill - 1);
                cv = clip_q(div_tz((s2 - s1) * 131072,
                                   longint'({32'd0, dt1}) + longint'({32'd0, dt2})));
            end
        end
        m = pts_reg;
        if (m >= 2) begin
            if (fill < m) m = fill;
            if (m == 2) begin
                ws = clip_q(diff_quot(fill - 2, fill - 1));
            end else if (m >= 3) begin
                mid = (fill - m) + m / 2;
                ws = clip_q(diff_quot(mid - 1, mid + 1));
            end
        end
        d.oldest = win_val[slot_of(0)][VAL_W-1:0];
        d.slope  = sl[Q_W-1:0];
        d.curv   = cv[Q_W-1:0];
        d.wslope = ws[Q_W-1:0];
        d.sat    = clipped;
        deriv_q.insert(deriv_q.size(), d);
    endtask

    task automatic compare_result();
        t_deriv d;
        if (deriv_q.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            o_errors++;
            return;
        end
        d = deriv_q[0];
        deriv_q.delete(0);
        if (i_oldest_value !== d.oldest) begin
            $display("%0t: oldest_value expected %0d actual %0d", $time, d.oldest,
                     i_oldest_value);
            o_errors++;
        end
        if (i_slope !== d.slope) begin
            $display("%0t: slope expected %0d actual %0d", $time, d.slope, i_slope);
            o_errors++;
        end
        if (i_curvature !== d.curv) begin
            $display("%0t: curvature expected %0d actual %0d", $time, d.curv,
                     i_curvature);
            o_errors++;
        end
        if (i_window_slope !== d.wslope) begin
            $display("%0t: window_slope expected %0d actual %0d", $time, d.wslope,
                     i_window_slope);
            o_errors++;
        end
        if (i_saturated !== d.sat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, d.sat, i_saturated);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot = 0;
            fill      = 0;
            cap_reg   = CAP_RESET;
            pts_reg   = WIN_RESET;
            o_errors  = 0;
            deriv_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_CAPACITY) cap_reg = i_cfg_data;
                else if (i_cfg_index == REG_WINDOW) pts_reg = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) push_and_predict(i_sample_time, i_sample_value);
            if (i_out_valid && !i_out_stall) compare_result();
        end
    end

endmodule

[tb/sv/tb_finite_difference_derivative.sv]
// ----------------------------------------------------------------------------
// tb_finite_difference_derivative
// drives timestamped samples and config writes into the derivative estimator
// with random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_finite_difference_derivative;
    import fdd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes that decode to no register, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int IDLE_PCT       = 11;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [TIME_W-1:0]       i_sample_time;
    logic signed [VAL_W-1:0] i_sample_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [VAL_W-1:0] o_oldest_value;
    logic signed [Q_W-1:0]   o_slope;
    logic signed [Q_W-1:0]   o_curvature;
    logic signed [Q_W-1:0]   o_window_slope;
    logic                    o_saturated;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    int                mismatches;
    int                outstanding;
    int                quiet_cycles;
    bit                calm;           // no idling on either side while set
    logic [TIME_W-1:0] clock_ticks;    // running sample timestamp
    logic signed [VAL_W-1:0] last_val;

    finite_difference_derivative dut (.*);

    fdd_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_sample_time  (i_sample_time),
        .i_sample_value (i_sample_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_oldest_value (o_oldest_value),
        .i_slope        (o_slope),
        .i_curvature    (o_curvature),
        .i_window_slope (o_window_slope),
        .i_saturated    (o_saturated),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (mismatches),
        .o_pending      (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side stalls at random except in the calm stretch
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // watchdog: cycles in which no channel completes a transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL finite_difference_derivative");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample transaction; the sender may idle first
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [VAL_W-1:0] v);
        @(negedge i_clk);
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_time  <= t;
        i_sample_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        clock_ticks = t;
        last_val    = v;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // config only changes once every result has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // random sample: mostly small forward steps, some zero gaps and wild jumps
    task automatic random_sample();
        logic [TIME_W-1:0]       t;
        logic signed [VAL_W-1:0] v;
        int                      r;
        r = $urandom_range(99);
        if (r < 6)       t = clock_ticks;
        else if (r < 12) t = $urandom;
        else             t = clock_ticks + $urandom_range(1, 40);
        r = $urandom_range(99);
        if (r < 4)       v = 24'sh7FFFFF;
        else if (r < 8)  v = 24'sh800000;
        else if (r < 40) v = VAL_W'($urandom);
        else             v = last_val + $signed(24'($urandom_range(2000))) - 24'sd1000;
        send_sample(t, v);
    endtask

    initial begin
        // capacity, window pairs; extremes, out-of-range codes, a lowered capacity
        logic [CFG_W-1:0] phase_cap [12] = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd5,
                                             7'd3, 7'd64, 7'd4, 7'd40, 7'd16, 7'd9};
        logic [CFG_W-1:0] phase_pts [12] = '{7'd0, 7'd2, 7'd3, 7'd64, 7'd127, 7'd1,
                                             7'd5, 7'd2, 7'd7, 7'd33, 7'd4, 7'd9};
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_sample_time  <= '0;
        i_sample_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_CAPACITY;
        i_cfg_data     <= '0;
        calm           = 1'b0;
        clock_ticks    = '0;
        last_val       = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: first point alone, zero gaps, wrap, full-scale swings
        send_sample(32'd100, 24'sd0);
        send_sample(32'd100, 24'sd5);             // zero gap
        send_sample(32'd101, 24'sd7);             // zero first gap in curvature
        send_sample(32'hFFFF_FFFF, 24'sd9);       // huge forward gap
        send_sample(32'd0, -24'sd3);              // wraps to a gap of one
        send_sample(32'd1, 24'sh7FFFFF);
        send_sample(32'd2, 24'sh800000);          // curvature saturates
        send_sample(32'd3, 24'sh7FFFFF);
        send_sample(32'd4, 24'sh800000);
        send_sample(32'd4, 24'sh7FFFFF);
        send_sample(32'd5, 24'sh800000);
        send_sample(32'h8000_0000, 24'sh7FFFFF);
        send_sample(32'h8000_0001, -24'sd1);
        send_sample(32'hFFFF_FFFE, 24'sd1);
        send_sample(32'hFFFF_FFFF, 24'sh800000);
        drain();

        // writes to unused indexes must leave both registers alone
        write_reg(REG_SPARE_A, 7'h7F);
        write_reg(REG_SPARE_B, 7'h55);
        repeat (6) send_sample(clock_ticks + 32'd3, last_val + 24'sd1);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_CAPACITY, phase_cap[ph]);
            write_reg(REG_WINDOW, phase_pts[ph]);
            for (int n = 0; n < 140; n++) begin
                calm = (ph == 6);
                random_sample();
            end
            calm = 1'b0;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS finite_difference_derivative");
        end else begin
            $display("FAIL finite_difference_derivative");
        end
        $finish;
    end

endmodule

[finite_difference_derivative.f]
rtl/fdd_pkg.sv
rtl/fdd_ram.sv
rtl/fdd_div.sv
rtl/fdd_datapath.sv
rtl/fdd_ctrl.sv
rtl/finite_difference_derivative.sv
tb/sv/fdd_checker.sv
tb/sv/tb_finite_difference_derivative.sv
